FILE: hdl/source_line_classifier_top_assert.svh
// ----------------------------------------------------------------------------
// Source line classifier assertion macros
// Shared assertion forms for the classifier top level; each macro collapses
// to nothing when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef SOURCE_LINE_CLASSIFIER_TOP_ASSERT_SVH
`define SOURCE_LINE_CLASSIFIER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, idle during reset.
`define SLC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, idle during reset.
`define SLC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SLC_ASSERT_SAME(label, ante, cons, msg)
`define SLC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: hdl/slc_pkg.sv
// ----------------------------------------------------------------------------
// Source line classifier package
// Shared types, codes and character constants of the line classifier.
// ----------------------------------------------------------------------------
package slc_pkg;

	// Language rule codes held in the mode register.
	localparam logic [1:0] MODE_C     = 2'd0;
	localparam logic [1:0] MODE_HASH  = 2'd1;
	localparam logic [1:0] MODE_PLAIN = 2'd2;

	// Register indexes of the configuration port.
	localparam logic REG_LANGUAGE_MODE = 1'b0;

	// Characters that the comment rules look for.
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_SLASH   = 8'h2F;
	localparam logic [7:0] CHAR_STAR    = 8'h2A;
	localparam logic [7:0] CHAR_HASH    = 8'h23;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_TAB     = 8'h09;
	localparam logic [7:0] CHAR_CR      = 8'h0D;

	// Default depth of the queue between front and back.
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	// Class of a finished line.
	typedef enum logic [1:0] {
		CLS_BLANK   = 2'd0,
		CLS_COMMENT = 2'd1,
		CLS_CODE    = 2'd2
	} line_class_t;

	// Write of one finished line into the queue.
	typedef struct packed {
		logic        wr;
		line_class_t cls;
	} cls_wr_t;

	// Space, tab, LF, VT, FF and CR count as whitespace.
	function automatic logic is_white(input logic [7:0] b);
		return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
	endfunction

endpackage

FILE: hdl/slc_front.sv
// ----------------------------------------------------------------------------
// Source line classifier front end
// Tracks the bytes of the current line and classifies it when it closes.
// ----------------------------------------------------------------------------
module slc_front import slc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_accept,
	input  logic [7:0] char_byte,
	input  logic       last_of_file,
	input  logic [1:0] mode,
	output cls_wr_t    cls_wr
);

	// Line state.
	logic       blk_open_q;
	logic [1:0] nsc_q;
	logic [7:0] first_q;
	logic       dslash_q;
	logic [7:0] prev_q;
	logic       open_q;
	logic       close_q;

	// State after taking the current byte into the line.
	logic [1:0] nsc_n;
	logic [7:0] first_n;
	logic       dslash_n;
	logic       open_n;
	logic       close_n;

	// The line as it stands when it closes.
	logic       is_nl;
	logic [1:0] v_nsc;
	logic [7:0] v_first;
	logic       v_dslash;
	logic       v_open;
	logic       v_close;
	logic       emit;
	logic       blk_n;
	line_class_t cls;

	assign is_nl = (char_byte == CHAR_NEWLINE);
	assign emit  = in_accept && (is_nl || last_of_file);

	// Take one byte into the line state.
	always_comb begin
		open_n   = open_q  || ((prev_q == CHAR_SLASH) && (char_byte == CHAR_STAR));
		close_n  = close_q || ((prev_q == CHAR_STAR) && (char_byte == CHAR_SLASH));
		nsc_n    = nsc_q;
		first_n  = first_q;
		dslash_n = dslash_q;
		if (nsc_q == 2'd0) begin
			if (!is_white(char_byte)) begin
				first_n = char_byte;
				nsc_n   = 2'd1;
			end
		end else if (nsc_q == 2'd1) begin
			if ((first_q == CHAR_SLASH) && (char_byte == CHAR_SLASH)) begin
				dslash_n = 1'b1;
			end
			nsc_n = 2'd2;
		end
	end

	// A newline closes the line as it was; any other byte joins it first.
	always_comb begin
		v_nsc    = is_nl ? nsc_q    : nsc_n;
		v_first  = is_nl ? first_q  : first_n;
		v_dslash = is_nl ? dslash_q : dslash_n;
		v_open   = is_nl ? open_q   : open_n;
		v_close  = is_nl ? close_q  : close_n;
	end

	// Classify the closing line and work out the block comment flag.
	always_comb begin
		cls   = CLS_CODE;
		blk_n = blk_open_q;
		if (v_nsc == 2'd0) begin
			cls = CLS_BLANK;
		end else begin
			unique case (mode)
				MODE_C: begin
					if (blk_open_q) begin
						cls = CLS_COMMENT;
						if (v_close) begin
							blk_n = 1'b0;
						end
					end else if (v_dslash) begin
						cls = CLS_COMMENT;
					end else if (v_open) begin
						cls = CLS_COMMENT;
						if (!v_close) begin
							blk_n = 1'b1;
						end
					end else begin
						cls = CLS_CODE;
					end
				end
				MODE_HASH: begin
					cls = (v_first == CHAR_HASH) ? CLS_COMMENT : CLS_CODE;
				end
				default: begin
					cls = CLS_CODE;
				end
			endcase
		end
	end

	assign cls_wr.wr  = emit;
	assign cls_wr.cls = cls;

	// Line state registers; a closed line or the end of file starts afresh.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_open_q <= 1'b0;
			nsc_q      <= 2'd0;
			first_q    <= '0;
			dslash_q   <= 1'b0;
			prev_q     <= '0;
			open_q     <= 1'b0;
			close_q    <= 1'b0;
		end else if (in_accept) begin
			if (last_of_file) begin
				blk_open_q <= 1'b0;
			end else if (emit) begin
				blk_open_q <= blk_n;
			end
			if (emit) begin
				nsc_q    <= 2'd0;
				first_q  <= '0;
				dslash_q <= 1'b0;
				prev_q   <= '0;
				open_q   <= 1'b0;
				close_q  <= 1'b0;
			end else begin
				nsc_q    <= nsc_n;
				first_q  <= first_n;
				dslash_q <= dslash_n;
				prev_q   <= char_byte;
				open_q   <= open_n;
				close_q  <= close_n;
			end
		end
	end

endmodule

FILE: hdl/slc_queue.sv
// ----------------------------------------------------------------------------
// Source line classifier result queue
// Holds finished line classes until the consumer pops them.
// ----------------------------------------------------------------------------
module slc_queue import slc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cls_wr_t     cls_wr,
	input  logic        pop,
	output logic        full,
	output logic        empty,
	output line_class_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	line_class_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop_ok;

	assign full   = (count_q == CNT_FULL);
	assign empty  = (count_q == '0);
	assign pop_ok = pop && !empty;
	assign head   = mem_q[rd_ptr_q];

	// Entry storage; the writer must write a word only while the queue has room, which the queue itself does not check.
	always_ff @(posedge clk) begin
		if (cls_wr.wr) begin
			mem_q[wr_ptr_q] <= cls_wr.cls;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (cls_wr.wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (cls_wr.wr && !pop_ok) begin
				count_q <= count_q + 1'b1;
			end else if (!cls_wr.wr && pop_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/source_line_classifier_top.sv
// Takes a file one byte per clock and gives one class word (blank, comment,
// code) per line. A byte is taken in every cycle in which the result queue is
// not full; the front end updates its line state for every accepted byte, which
// sets this rate of one byte per cycle. The class of a line is written into a
// QUEUE_DEPTH-entry queue in the cycle its newline or last byte is accepted and
// shows on the result ports once the lines ahead of it have been popped. The mode
// register should be written only while no line result is outstanding.
// ----------------------------------------------------------------------------
// Source line classifier top level
// Configuration port, classifying front end and result queue.
// ----------------------------------------------------------------------------
`include "source_line_classifier_top_assert.svh"
module source_line_classifier_top import slc_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// Byte input
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_byte,
	input  logic        last_of_file,
	// Class output
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  line_class,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [1:0]  mode_q;
	logic        in_accept;
	logic        reg_hit;
	cls_wr_t     cls_wr;
	line_class_t head;

	assign pready    = 1'b1;
	assign in_accept = push && !full;
	assign reg_hit   = (paddr[2] == REG_LANGUAGE_MODE);

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			mode_q <= pwdata[1:0];
		end
	end

	// Register read back.
	assign prdata = reg_hit ? {30'd0, mode_q} : 32'd0;

	slc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_accept    (in_accept),
		.char_byte    (char_byte),
		.last_of_file (last_of_file),
		.mode         (mode_q),
		.cls_wr       (cls_wr)
	);

	slc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.cls_wr (cls_wr),
		.pop    (pop),
		.full   (full),
		.empty  (empty),
		.head   (head)
	);

	assign line_class = head;

	// Checks.
	`SLC_ASSERT_SAME(a_newline_writes, in_accept && (char_byte == CHAR_NEWLINE), cls_wr.wr, "newline did not close a line")
	`SLC_ASSERT_SAME(a_last_writes, in_accept && last_of_file, cls_wr.wr, "last byte did not close a line")
	`SLC_ASSERT_NEXT(a_pop_frees, pop && !empty && !cls_wr.wr, !full, "queue still full after a pop")
	`SLC_ASSERT_NEXT(a_mode_write, psel && penable && pwrite && reg_hit, mode_q == $past(pwdata[1:0]), "mode write lost")

endmodule

FILE: tb/source_line_classifier_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Source line classifier testbench
// Feeds byte streams of text files through the byte input, writes the mode
// register between files and once within a line, and compares every class word that comes out with a
// line-by-line predictor that runs alongside.
// ----------------------------------------------------------------------------
module source_line_classifier_top_test;
	import slc_pkg::*;

	// Mode value that the rules leave unused; it behaves like plain mode.
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [2:0] MODE_ADDR  = 3'(REG_LANGUAGE_MODE) * 3'd4;

	// Further characters used to build text.
	localparam logic [7:0] CHAR_VT     = 8'h0B;
	localparam logic [7:0] CHAR_FF     = 8'h0C;
	localparam logic [7:0] CHAR_A      = 8'h61;
	localparam logic [7:0] CHAR_ZERO   = 8'h00;
	localparam logic [7:0] CHAR_TOP    = 8'hFF;

	localparam int PHASES        = 12;
	localparam int PHASE_BYTES   = 125;
	localparam int HOLD_CYCLES   = 80;
	localparam int SETTLE_CYCLES = 4;

	// One row of the directed table: either a mode write or one byte.
	typedef struct packed {
		logic        cfg;
		logic [1:0]  mode;
		logic [7:0]  ch;
		logic        last;
		logic        typed;
		line_class_t cls;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  char_byte;
	logic        last_of_file;
	logic        empty;
	logic        pop;
	logic [1:0]  line_class;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Predictor state: mode register and the state of the open line.
	logic [1:0]  cur_mode;
	logic        comment_open;
	logic [1:0]  nonspace_cnt;
	logic [7:0]  lead_byte;
	logic        slash_pair;
	logic [7:0]  prior_byte;
	logic        open_seen;
	logic        close_seen;

	line_class_t class_due_q[$];
	logic [7:0]  text_q[$];
	dir_row_t    dir_tab[25];
	int          mismatch_count;
	int          burst_left;
	bit          hold_req;

	source_line_classifier_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.char_byte    (char_byte),
		.last_of_file (last_of_file),
		.empty        (empty),
		.pop          (pop),
		.line_class   (line_class),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Whitespace as the line rules see it.
	function automatic bit is_space(input logic [7:0] b);
		case (b)
			CHAR_SPACE, CHAR_TAB, CHAR_NEWLINE, CHAR_VT, CHAR_FF, CHAR_CR: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	task automatic clear_line_state();
		nonspace_cnt = 2'd0;
		lead_byte    = 8'h00;
		slash_pair   = 1'b0;
		prior_byte   = 8'h00;
		open_seen    = 1'b0;
		close_seen   = 1'b0;
	endtask

	// Fold one byte of text into the open line.
	task automatic absorb_byte(input logic [7:0] b);
		if (prior_byte == CHAR_SLASH && b == CHAR_STAR)
			open_seen = 1'b1;
		if (prior_byte == CHAR_STAR && b == CHAR_SLASH)
			close_seen = 1'b1;
		if (nonspace_cnt == 2'd0) begin
			if (!is_space(b)) begin
				lead_byte    = b;
				nonspace_cnt = 2'd1;
			end
		end else if (nonspace_cnt == 2'd1) begin
			if (lead_byte == CHAR_SLASH && b == CHAR_SLASH)
				slash_pair = 1'b1;
			nonspace_cnt = 2'd2;
		end
		prior_byte = b;
	endtask

	// Class of the finished line under the current mode; updates the
	// block comment flag in C mode.
	task automatic end_line(output line_class_t c);
		if (nonspace_cnt == 2'd0) begin
			c = CLS_BLANK;
		end else begin
			case (cur_mode)
				MODE_C: begin
					if (comment_open) begin
						c = CLS_COMMENT;
						if (close_seen)
							comment_open = 1'b0;
					end else if (slash_pair) begin
						c = CLS_COMMENT;
					end else if (open_seen) begin
						c = CLS_COMMENT;
						if (!close_seen)
							comment_open = 1'b1;
					end else begin
						c = CLS_CODE;
					end
				end
				MODE_HASH: c = (lead_byte == CHAR_HASH) ? CLS_COMMENT : CLS_CODE;
				default:   c = CLS_CODE;
			endcase
		end
		clear_line_state();
	endtask

	// Predict the class word, if any, that one accepted byte causes.
	task automatic classify_next_byte(input logic [7:0] b, input logic last,
			output bit produced, output line_class_t c);
		produced = 1'b0;
		c = CLS_BLANK;
		if (b == CHAR_NEWLINE) begin
			end_line(c);
			produced = 1'b1;
		end else begin
			absorb_byte(b);
			if (last) begin
				end_line(c);
				produced = 1'b1;
			end
		end
		// The end of a file also drops any open block comment.
		if (last) begin
			comment_open = 1'b0;
			clear_line_state();
		end
	endtask

	// Offer one byte and wait until it is taken; the sender may idle between
	// bursts unless a receiver hold-off is under way.
	task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
			input line_class_t typed_cls);
		int          gap;
		bit          produced;
		line_class_t c;
		if (burst_left == 0 && !hold_req) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				push = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 16);
		end
		push         = 1'b1;
		char_byte    = b;
		last_of_file = last;
		do @(posedge clk); while (full);
		classify_next_byte(b, last, produced, c);
		if (produced)
			class_due_q.push_back(typed ? typed_cls : c);
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
	endtask

	// Stop sending and wait until every predicted word has been taken.
	task automatic wait_drained();
		push = 1'b0;
		while (class_due_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write the mode register in a setup phase followed by an access phase.
	task automatic write_mode(input logic [1:0] m);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = MODE_ADDR;
		pwdata  = {30'($urandom()), m};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		cur_mode = m;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	function automatic dir_row_t row_byte(input logic [7:0] ch, input logic last);
		return '{cfg: 1'b0, mode: MODE_PLAIN, ch: ch, last: last, typed: 1'b0,
			cls: CLS_BLANK};
	endfunction

	function automatic dir_row_t row_known(input logic [7:0] ch, input logic last,
			input line_class_t c);
		return '{cfg: 1'b0, mode: MODE_PLAIN, ch: ch, last: last, typed: 1'b1, cls: c};
	endfunction

	function automatic dir_row_t row_mode(input logic [1:0] m);
		return '{cfg: 1'b1, mode: m, ch: CHAR_ZERO, last: 1'b0, typed: 1'b0,
			cls: CLS_BLANK};
	endfunction

	function automatic logic [7:0] space_byte();
		case ($urandom_range(0, 4))
			0:       return CHAR_TAB;
			1:       return CHAR_VT;
			2:       return CHAR_FF;
			3:       return CHAR_CR;
			default: return CHAR_SPACE;
		endcase
	endfunction

	// Body text: comment markers, spaces, letters and any other byte but
	// the newline.
	function automatic logic [7:0] filler_byte();
		logic [7:0] b;
		case ($urandom_range(0, 9))
			0:       b = CHAR_SLASH;
			1:       b = CHAR_STAR;
			2:       b = CHAR_HASH;
			3:       b = space_byte();
			4, 5:    b = 8'($urandom_range(0, 255));
			default: b = CHAR_A + 8'($urandom_range(0, 25));
		endcase
		return (b == CHAR_NEWLINE) ? CHAR_VT : b;
	endfunction

	task automatic add_filler(input int lo, input int hi);
		repeat ($urandom_range(lo, hi)) text_q.push_back(filler_byte());
	endtask

	// Append one line of a chosen shape, newline included.
	task automatic add_line();
		int kind;
		kind = $urandom_range(0, 9);
		if (kind != 0)
			repeat ($urandom_range(0, 2)) text_q.push_back(space_byte());
		case (kind)
			0: repeat ($urandom_range(0, 3)) text_q.push_back(space_byte());
			1: begin
				text_q.push_back(CHAR_SLASH);
				text_q.push_back(CHAR_SLASH);
				add_filler(0, 5);
			end
			2: begin
				text_q.push_back(CHAR_SLASH);
				text_q.push_back(CHAR_STAR);
				add_filler(0, 5);
				if ($urandom_range(0, 2) == 0) begin
					text_q.push_back(CHAR_STAR);
					text_q.push_back(CHAR_SLASH);
				end
			end
			3: begin
				add_filler(0, 3);
				text_q.push_back(CHAR_STAR);
				text_q.push_back(CHAR_SLASH);
				add_filler(0, 3);
			end
			4: begin
				text_q.push_back(CHAR_HASH);
				add_filler(0, 5);
			end
			7: begin
				// Two slashes that are not adjacent.
				text_q.push_back(CHAR_SLASH);
				text_q.push_back(space_byte());
				text_q.push_back(CHAR_SLASH);
				add_filler(0, 3);
			end
			8: repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
			9: begin
				// Open and close markers sharing the star.
				text_q.push_back(CHAR_SLASH);
				text_q.push_back(CHAR_STAR);
				text_q.push_back(CHAR_SLASH);
				add_filler(0, 3);
			end
			default: begin
				text_q.push_back(CHAR_A + 8'($urandom_range(0, 25)));
				add_filler(0, 6);
			end
		endcase
		text_q.push_back(CHAR_NEWLINE);
	endtask

	// A file of one to six lines; about half the files end without a final newline.
	task automatic build_file();
		text_q.delete();
		repeat ($urandom_range(1, 6)) add_line();
		if ($urandom_range(0, 1) == 1 && text_q.size() > 1)
			void'(text_q.pop_back());
	endtask

	// Receiver: stalls on a changing pattern, and holds off for a long
	// stretch when asked.
	initial begin
		int pat_cycles;
		int pattern;
		int hold_cnt;
		pat_cycles = 0;
		pattern    = 0;
		hold_cnt   = 0;
		pop        = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && hold_cnt == 0)
				hold_cnt = HOLD_CYCLES;
			if (hold_cnt > 0) begin
				pop = 1'b0;
				hold_cnt--;
				if (hold_cnt == 0)
					hold_req = 1'b0;
			end else begin
				case (pattern)
					0:       pop = 1'b1;
					1:       pop = 1'($urandom_range(0, 1));
					2:       pop = (pat_cycles % 4 == 0);
					default: pop = ($urandom_range(0, 3) != 0);
				endcase
				pat_cycles++;
				if (pat_cycles % 50 == 0)
					pattern = $urandom_range(0, 3);
			end
		end
	end

	// Compare each taken class word with the oldest prediction.
	always @(posedge clk) begin
		line_class_t want;
		if (arst_n && pop && !empty) begin
			if (class_due_q.size() == 0) begin
				$display("%0t: class word %0d arrived with none expected", $time, line_class);
				mismatch_count++;
			end else begin
				want = class_due_q.pop_front();
				if (line_class !== want) begin
					$display("%0t: line_class expected %0d, actual %0d", $time, want,
						line_class);
					mismatch_count++;
				end
			end
		end
	end

	// Main sequence: reset, directed table, random files, drain.
	initial begin
		int ph;
		int sent;
		mismatch_count = 0;
		burst_left     = 0;
		hold_req       = 1'b0;
		arst_n         = 1'b0;
		push           = 1'b0;
		char_byte      = 8'h00;
		last_of_file   = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = 3'd0;
		pwdata         = 32'd0;
		cur_mode       = MODE_PLAIN;
		comment_open   = 1'b0;
		clear_line_state();

		dir_tab = '{
			row_known(CHAR_NEWLINE, 1'b0, CLS_BLANK), // empty line after reset
			row_known(CHAR_A, 1'b1, CLS_CODE),        // last byte joins the line
			row_mode(MODE_C),
			row_byte(CHAR_SLASH, 1'b0),
			row_byte(CHAR_SLASH, 1'b0),
			row_byte(CHAR_NEWLINE, 1'b0),
			row_byte(CHAR_SLASH, 1'b0),               // overlapping markers
			row_byte(CHAR_STAR, 1'b0),
			row_byte(CHAR_SLASH, 1'b0),
			row_byte(CHAR_NEWLINE, 1'b0),
			row_byte(CHAR_SLASH, 1'b0),               // block comment opens
			row_byte(CHAR_STAR, 1'b0),
			row_byte(CHAR_NEWLINE, 1'b0),
			row_byte(CHAR_TAB, 1'b0),
			row_known(CHAR_NEWLINE, 1'b0, CLS_BLANK), // blank inside the comment
			row_byte(CHAR_STAR, 1'b0),
			row_byte(CHAR_SLASH, 1'b0),
			row_byte(CHAR_NEWLINE, 1'b0),
			row_byte(CHAR_TOP, 1'b0),
			row_mode(MODE_HASH),                      // mode changes within a line
			row_byte(CHAR_NEWLINE, 1'b0),
			row_byte(CHAR_HASH, 1'b0),
			row_byte(CHAR_ZERO, 1'b1),
			row_mode(MODE_SPARE),
			row_known(CHAR_NEWLINE, 1'b1, CLS_BLANK)  // final newline, no extra line
		};

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].cfg) begin
				wait_drained();
				write_mode(dir_tab[i].mode);
			end else begin
				send_byte(dir_tab[i].ch, dir_tab[i].last, dir_tab[i].typed,
					dir_tab[i].cls);
			end
		end

		// Random files, a mode per phase; two phases start with a long
		// receiver hold-off so that the result queue fills.
		for (ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			write_mode(2'(ph % 4));
			if (ph == 3 || ph == 8)
				hold_req = 1'b1;
			sent = 0;
			while (sent < PHASE_BYTES) begin
				build_file();
				foreach (text_q[k])
					send_byte(text_q[k], k == text_q.size() - 1, 1'b0, CLS_BLANK);
				sent += text_q.size();
				if ($urandom_range(0, 15) == 0)
					wait_drained();
			end
		end

		wait_drained();
		repeat (20) @(negedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Run limit.
	initial begin
		#20000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
